@@ hdl/aacs_pkg.sv @@
`default_nettype none

package aacs_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SEQ_LEN_W = 11;
  localparam int unsigned CYC_W     = 7;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = SEQ_LEN_W;
  // Cycle plus a window length (at most 127 + 64) fits this width
  localparam int unsigned CYC_EXT_W = CYC_W + 1;

  // Default array geometry and tile schedule
  localparam int unsigned ARRAY_COLS_DEF        = 16;
  localparam int unsigned ARRAY_ROWS_DEF        = 16;
  localparam int unsigned TILE_CYCLES_DEF       = 72;
  localparam int unsigned MAX_TILES_DEF         = 64;
  localparam int unsigned QK_FIRST_CYCLE_DEF    = 16;
  localparam int unsigned SCORE_FIRST_CYCLE_DEF = 32;

  // Register reset values
  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RST   = '0;
  localparam logic [CYC_W-1:0]     MAX_DIFF_RST  = CYC_W'(48);
  localparam logic [CYC_W-1:0]     SUB_MAX_RST   = CYC_W'(49);
  localparam logic [CYC_W-1:0]     SCALE_RST     = CYC_W'(50);
  localparam logic [CYC_W-1:0]     PWL_FIRST_RST = CYC_W'(51);
  localparam logic [CYC_W-1:0]     PWL_LAST_RST  = CYC_W'(54);
  localparam logic [CYC_W-1:0]     ROW_SUM_RST   = CYC_W'(55);
  localparam logic [CYC_W-1:0]     PV_FIRST_RST  = CYC_W'(56);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_LEN   = 3'd0,
    REG_MAX_DIFF  = 3'd1,
    REG_SUB_MAX   = 3'd2,
    REG_SCALE     = 3'd3,
    REG_PWL_FIRST = 3'd4,
    REG_PWL_LAST  = 3'd5,
    REG_ROW_SUM   = 3'd6,
    REG_PV_FIRST  = 3'd7
  } aacs_reg_e;

  typedef enum logic [OP_W-1:0] {
    CMP_RESET      = 3'd0,
    CMP_UPDATE     = 3'd1,
    CMP_PROP_DIFF  = 3'd2,
    CMP_PROP_MAX   = 3'd3,
    CMP_PROP_EXP2  = 3'd4,
    CMP_PROP_ZERO  = 3'd5
  } aacs_cmp_op_e;

  typedef enum logic [OP_W-1:0] {
    DOWN_SUB_MAX = 3'd0,
    DOWN_SCALE   = 3'd1,
    DOWN_PWL     = 3'd2,
    DOWN_ROW_SUM = 3'd3,
    DOWN_PV      = 3'd4
  } aacs_down_op_e;

  // Schedule registers seen by the decoder
  typedef struct packed {
    logic [CYC_W-1:0] max_diff;
    logic [CYC_W-1:0] sub_max;
    logic [CYC_W-1:0] scale;
    logic [CYC_W-1:0] pwl_first;
    logic [CYC_W-1:0] pwl_last;
    logic [CYC_W-1:0] row_sum;
    logic [CYC_W-1:0] pv_first;
  } aacs_sched_t;

  // Plan position for the item being processed
  typedef struct packed {
    logic             active;
    logic [CYC_W-1:0] cycle;
    logic             first_key;
    logic             last;
  } aacs_pos_t;

  typedef struct packed {
    logic              word_valid;
    logic              qry_load;
    logic [IDX_W-1:0]  qry_idx;
    logic              qk_go;
    logic [IDX_W-1:0]  qk_idx;
    logic              cmp_en;
    aacs_cmp_op_e      cmp_op;
    logic [IDX_W-1:0]  cmp_idx;
    logic              down_go;
    aacs_down_op_e     down_op;
    logic [IDX_W-1:0]  down_idx;
    logic              last_of_plan;
  } aacs_word_t;

endpackage

`default_nettype wire

@@ hdl/aacs_tile_walker.sv @@
`default_nettype none

module aacs_tile_walker import aacs_pkg::*; #(
  parameter int unsigned ARRAY_COLS  = ARRAY_COLS_DEF,
  parameter int unsigned TILE_CYCLES = TILE_CYCLES_DEF,
  parameter int unsigned MAX_TILES   = MAX_TILES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 restart_i,
  input  wire logic [SEQ_LEN_W-1:0] seq_len_i,
  output aacs_pos_t                 pos_o
);

  localparam int unsigned TileW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int unsigned ColW  = $clog2(ARRAY_COLS + 1);
  localparam int unsigned ProdW = TileW + 1 + ColW;
  localparam int unsigned CmpW  = (ProdW > SEQ_LEN_W) ? ProdW : SEQ_LEN_W;

  logic             running_q, running_d;
  logic [CYC_W-1:0] cyc_q, cyc_d;
  logic [TileW-1:0] key_q, key_d;
  logic [TileW-1:0] qry_q, qry_d;

  logic             running_now;
  logic [CYC_W-1:0] cyc_now;
  logic [TileW-1:0] key_now, qry_now;
  logic             last_cycle, last_key, last_query;

  // Tile t is the last one when (t+1)*cols covers the sequence, or at the cap
  function automatic logic is_last_tile(input logic [TileW-1:0] t,
                                        input logic [SEQ_LEN_W-1:0] s);
    logic [TileW:0]   t_inc;
    logic [CmpW-1:0]  span;
    t_inc = {1'b0, t} + (TileW+1)'(1);
    span  = CmpW'(t_inc) * CmpW'(ARRAY_COLS);
    return (span >= CmpW'(s)) || (t >= TileW'(MAX_TILES - 1));
  endfunction

  always_comb begin
    running_now = (restart_i | running_q) & (seq_len_i != '0);
    cyc_now     = restart_i ? '0 : cyc_q;
    key_now     = restart_i ? '0 : key_q;
    qry_now     = restart_i ? '0 : qry_q;
    last_cycle  = cyc_now >= CYC_W'(TILE_CYCLES - 1);
    last_key    = is_last_tile(key_now, seq_len_i);
    last_query  = is_last_tile(qry_now, seq_len_i);

    pos_o.active    = running_now;
    pos_o.cycle     = cyc_now;
    pos_o.first_key = key_now == '0;
    pos_o.last      = running_now & last_cycle & last_key & last_query;

    running_d = running_now;
    cyc_d     = cyc_now;
    key_d     = key_now;
    qry_d     = qry_now;
    if (running_now) begin
      if (last_cycle && last_key && last_query) begin
        running_d = 1'b0;
        cyc_d     = '0;
        key_d     = '0;
        qry_d     = '0;
      end else if (!last_cycle) begin
        cyc_d = cyc_now + CYC_W'(1);
      end else begin
        cyc_d = '0;
        if (!last_key) begin
          key_d = key_now + TileW'(1);
        end else begin
          key_d = '0;
          qry_d = qry_now + TileW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cyc_q     <= '0;
      key_q     <= '0;
      qry_q     <= '0;
    end else if (step_i) begin
      running_q <= running_d;
      cyc_q     <= cyc_d;
      key_q     <= key_d;
      qry_q     <= qry_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/aacs_word_decoder.sv @@
`default_nettype none

module aacs_word_decoder import aacs_pkg::*; #(
  parameter int unsigned ARRAY_COLS        = ARRAY_COLS_DEF,
  parameter int unsigned ARRAY_ROWS        = ARRAY_ROWS_DEF,
  parameter int unsigned QK_FIRST_CYCLE    = QK_FIRST_CYCLE_DEF,
  parameter int unsigned SCORE_FIRST_CYCLE = SCORE_FIRST_CYCLE_DEF
) (
  input  aacs_pos_t   pos_i,
  input  aacs_sched_t sched_i,
  output aacs_word_t  word_o
);

  localparam logic [CYC_EXT_W-1:0] QkLo    = CYC_EXT_W'(QK_FIRST_CYCLE);
  localparam logic [CYC_EXT_W-1:0] QkHi    = CYC_EXT_W'(QK_FIRST_CYCLE + ARRAY_COLS);
  localparam logic [CYC_EXT_W-1:0] ScoreLo = CYC_EXT_W'(SCORE_FIRST_CYCLE);
  localparam logic [CYC_EXT_W-1:0] ScoreHi = CYC_EXT_W'(SCORE_FIRST_CYCLE + ARRAY_COLS);

  logic [CYC_W-1:0]     c;
  logic [CYC_EXT_W-1:0] cx;
  logic [CYC_EXT_W-1:0] pv_end;
  logic                 in_pwl, in_pv, in_score;

  always_comb begin
    c        = pos_i.cycle;
    cx       = {1'b0, c};
    pv_end   = {1'b0, sched_i.pv_first} + CYC_EXT_W'(ARRAY_ROWS);
    in_pwl   = (c >= sched_i.pwl_first) && (c <= sched_i.pwl_last);
    in_pv    = (c >= sched_i.pv_first) && (cx < pv_end);
    in_score = (cx >= ScoreLo) && (cx < ScoreHi);

    word_o = '0;
    if (pos_i.active) begin
      word_o.word_valid   = 1'b1;
      word_o.last_of_plan = pos_i.last;

      if (cx < CYC_EXT_W'(ARRAY_COLS)) begin
        word_o.qry_load = 1'b1;
        word_o.qry_idx  = IDX_W'(c);
      end
      if ((cx >= QkLo) && (cx < QkHi)) begin
        word_o.qk_go  = 1'b1;
        word_o.qk_idx = IDX_W'(cx - QkLo);
      end

      // compare unit, highest priority first
      if ((c == '0) && pos_i.first_key) begin
        word_o.cmp_en = 1'b1;
        word_o.cmp_op = CMP_RESET;
      end else if (in_score) begin
        word_o.cmp_en  = 1'b1;
        word_o.cmp_op  = CMP_UPDATE;
        word_o.cmp_idx = IDX_W'(cx - ScoreLo);
      end else if (c == sched_i.max_diff) begin
        word_o.cmp_en = 1'b1;
        word_o.cmp_op = CMP_PROP_DIFF;
      end else if (c == sched_i.sub_max) begin
        word_o.cmp_en = 1'b1;
        word_o.cmp_op = CMP_PROP_MAX;
      end else if (in_pwl) begin
        word_o.cmp_en  = 1'b1;
        word_o.cmp_op  = CMP_PROP_EXP2;
        word_o.cmp_idx = IDX_W'(c - sched_i.pwl_first);
      end else if (c == sched_i.row_sum) begin
        word_o.cmp_en = 1'b1;
        word_o.cmp_op = CMP_PROP_ZERO;
      end

      // down path
      if (c == sched_i.sub_max) begin
        word_o.down_go = 1'b1;
        word_o.down_op = DOWN_SUB_MAX;
      end else if (c == sched_i.scale) begin
        word_o.down_go = 1'b1;
        word_o.down_op = DOWN_SCALE;
      end else if (in_pwl) begin
        word_o.down_go  = 1'b1;
        word_o.down_op  = DOWN_PWL;
        word_o.down_idx = IDX_W'(c - sched_i.pwl_first);
      end else if (c == sched_i.row_sum) begin
        word_o.down_go = 1'b1;
        word_o.down_op = DOWN_ROW_SUM;
      end else if (in_pv) begin
        word_o.down_go  = 1'b1;
        word_o.down_op  = DOWN_PV;
        word_o.down_idx = IDX_W'(c - sched_i.pv_first);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/attention_array_cycle_sequencer_unit.sv @@
// An input tick is held in the input register, then decoded into the output register.
// Throughput: one tick per cycle unless stalled; input and output registers advance together.
// The input stalls only when both registers are full and the output is stalled.
// Reset (rst_ni low, asynchronous): plan idle, counters zero, both registers empty,
// schedule registers at their defaults (sequence length zero).
`default_nettype none

module attention_array_cycle_sequencer_unit import aacs_pkg::*; #(
  parameter int unsigned ARRAY_COLS        = ARRAY_COLS_DEF,
  parameter int unsigned ARRAY_ROWS        = ARRAY_ROWS_DEF,
  parameter int unsigned TILE_CYCLES       = TILE_CYCLES_DEF,
  parameter int unsigned MAX_TILES         = MAX_TILES_DEF,
  parameter int unsigned QK_FIRST_CYCLE    = QK_FIRST_CYCLE_DEF,
  parameter int unsigned SCORE_FIRST_CYCLE = SCORE_FIRST_CYCLE_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // tick input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  restart_i,
  // control word output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       word_valid_o,
  output logic                       qry_load_o,
  output logic [IDX_W-1:0]           qry_idx_o,
  output logic                       qk_go_o,
  output logic [IDX_W-1:0]           qk_idx_o,
  output logic                       cmp_en_o,
  output logic [OP_W-1:0]            cmp_op_o,
  output logic [IDX_W-1:0]           cmp_idx_o,
  output logic                       down_go_o,
  output logic [OP_W-1:0]            down_op_o,
  output logic [IDX_W-1:0]           down_idx_o,
  output logic                       last_of_plan_o
);

  // ---------------------------------------------------------------------------
  // Schedule registers; write only while no tick is in flight (the block does not enforce this)
  // ---------------------------------------------------------------------------
  logic [SEQ_LEN_W-1:0] seq_len_q;
  aacs_sched_t          sched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q         <= SEQ_LEN_RST;
      sched_q.max_diff  <= MAX_DIFF_RST;
      sched_q.sub_max   <= SUB_MAX_RST;
      sched_q.scale     <= SCALE_RST;
      sched_q.pwl_first <= PWL_FIRST_RST;
      sched_q.pwl_last  <= PWL_LAST_RST;
      sched_q.row_sum   <= ROW_SUM_RST;
      sched_q.pv_first  <= PV_FIRST_RST;
    end else if (cfg_we_i) begin
      case (aacs_reg_e'(cfg_index_i))
        REG_SEQ_LEN:   seq_len_q         <= cfg_data_i[SEQ_LEN_W-1:0];
        REG_MAX_DIFF:  sched_q.max_diff  <= cfg_data_i[CYC_W-1:0];
        REG_SUB_MAX:   sched_q.sub_max   <= cfg_data_i[CYC_W-1:0];
        REG_SCALE:     sched_q.scale     <= cfg_data_i[CYC_W-1:0];
        REG_PWL_FIRST: sched_q.pwl_first <= cfg_data_i[CYC_W-1:0];
        REG_PWL_LAST:  sched_q.pwl_last  <= cfg_data_i[CYC_W-1:0];
        REG_ROW_SUM:   sched_q.row_sum   <= cfg_data_i[CYC_W-1:0];
        REG_PV_FIRST:  sched_q.pv_first  <= cfg_data_i[CYC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: input register -> decode -> output register.
  // advance is high whenever the output register can take a new word;
  // the held tick then moves on and a fresh tick can enter behind it.
  // ---------------------------------------------------------------------------
  logic       in_full_q;
  logic       restart_q;
  logic       out_full_q;
  logic       advance;
  logic       fire;
  logic       in_take;
  aacs_word_t word_q;
  aacs_word_t word_d;
  aacs_pos_t  pos;

  assign advance    = ~out_full_q | ~out_stall_i;
  assign fire       = in_full_q & advance;
  assign in_stall_o = in_full_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_full_q <= 1'b1;
      end else if (fire) begin
        in_full_q <= 1'b0;
      end
      if (advance) begin
        out_full_q <= in_full_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      restart_q <= restart_i;
    end
    if (fire) begin
      word_q <= word_d;
    end
  end

  // Tile and cycle counters; they step once per tick moved to the output
  aacs_tile_walker #(
    .ARRAY_COLS  (ARRAY_COLS),
    .TILE_CYCLES (TILE_CYCLES),
    .MAX_TILES   (MAX_TILES)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .restart_i (restart_q),
    .seq_len_i (seq_len_q),
    .pos_o     (pos)
  );

  // Cycle-number decode into the control word
  aacs_word_decoder #(
    .ARRAY_COLS        (ARRAY_COLS),
    .ARRAY_ROWS        (ARRAY_ROWS),
    .QK_FIRST_CYCLE    (QK_FIRST_CYCLE),
    .SCORE_FIRST_CYCLE (SCORE_FIRST_CYCLE)
  ) u_decoder (
    .pos_i   (pos),
    .sched_i (sched_q),
    .word_o  (word_d)
  );

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign out_valid_o    = out_full_q;
  assign word_valid_o   = word_q.word_valid;
  assign qry_load_o     = word_q.qry_load;
  assign qry_idx_o      = word_q.qry_idx;
  assign qk_go_o        = word_q.qk_go;
  assign qk_idx_o       = word_q.qk_idx;
  assign cmp_en_o       = word_q.cmp_en;
  assign cmp_op_o       = word_q.cmp_op;
  assign cmp_idx_o      = word_q.cmp_idx;
  assign down_go_o      = word_q.down_go;
  assign down_op_o      = word_q.down_op;
  assign down_idx_o     = word_q.down_idx;
  assign last_of_plan_o = word_q.last_of_plan;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an invalid word carries no wave at all
  a_idle_word_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !word_valid_o) |->
      (!qry_load_o && !qk_go_o && !cmp_en_o && !down_go_o && !last_of_plan_o))
    else $error("invalid word carries an operation");

  // compare reset comes only on cycle zero, alongside the first query wave
  a_cmp_reset_cycle0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cmp_en_o && (cmp_op_o == CMP_RESET)) |->
      (qry_load_o && (qry_idx_o == '0)))
    else $error("compare reset off cycle zero");

  // a tick moved on while the output is held would be lost
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(word_q)))
    else $error("stalled control word overwritten");

endmodule

`default_nettype wire
